FILE: sv/ptvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvc_pkg
// Shared types, constants and fixed-point helpers for the path-tracking
// velocity corrector: Q4.12 data, register map, cosine table.
// ----------------------------------------------------------------------------
package ptvc_pkg;

	localparam int DATA_WIDTH      = 16;
	localparam int FRAC_BITS       = 12;
	localparam int COS_TABLE_DEPTH = 256;
	localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH);
	localparam int ALPHA_BITS      = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = (DATA_WIDTH > ALPHA_BITS) ? DATA_WIDTH : ALPHA_BITS;

	// wide enough for a full product plus rounding and a few sums
	localparam int ACC_W = 2 * DATA_WIDTH + 2;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [ALPHA_BITS-1:0]        alpha_t;
	typedef logic signed [ACC_W-1:0]      acc_t;

	typedef enum logic {
		KIND_UPDATE  = 1'b0,
		KIND_COMMAND = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_LONGITUDINAL = 3'd0,
		CFG_GAIN_LATERAL      = 3'd1,
		CFG_GAIN_HEADING      = 3'd2,
		CFG_FILTER_ALPHA      = 3'd3,
		CFG_MIN_LINEAR        = 3'd4,
		CFG_MAX_LINEAR        = 3'd5,
		CFG_MIN_ANGULAR       = 3'd6,
		CFG_MAX_ANGULAR       = 3'd7
	} cfg_index_t;

	typedef struct packed {
		data_t  gain_longitudinal;
		data_t  gain_lateral;
		data_t  gain_heading;
		alpha_t filter_alpha;
		data_t  min_linear;
		data_t  max_linear;
		data_t  min_angular;
		data_t  max_angular;
	} cfg_t;

	typedef struct packed {
		data_t filtered_long_error;
		data_t lateral_error;
		data_t heading_error;
		data_t cos_lateral;
	} track_t;

	localparam data_t DATA_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam data_t DATA_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam data_t ONE_Q     = data_t'(longint'(1) << FRAC_BITS);
	localparam data_t NEG_ONE_Q = -ONE_Q;

	localparam longint QMUL_HALF  = longint'(1) << (FRAC_BITS - 1);
	localparam longint ALPHA_HALF = longint'(1) << (ALPHA_BITS - 1);

	// 2*pi constants for the cosine index and table
	localparam longint unsigned TWO_PI_Q32 = 64'd26986075409;
	localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;
	localparam longint unsigned COS_TWO_PI =
		(TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

	// index = (|lat| * depth + 2pi/2) / 2pi, done as multiply by a ceiling
	// reciprocal; exact for every numerator below 2^COS_NUM_W
	localparam int COS_NUM_W       = DATA_WIDTH + COS_IDX_W;
	localparam int COS_DIV_W       = $clog2(COS_TWO_PI);
	localparam int COS_RECIP_SHIFT = COS_NUM_W + COS_DIV_W;
	localparam int COS_RECIP_W     = COS_NUM_W + 1;
	localparam longint unsigned COS_RECIP =
		((64'd1 << COS_RECIP_SHIFT) + COS_TWO_PI - 64'd1) / COS_TWO_PI;

	typedef data_t cos_tab_t [COS_TABLE_DEPTH];

	function automatic data_t sat_data(input acc_t v);
		if (v > acc_t'(DATA_MAX))
			return DATA_MAX;
		else if (v < acc_t'(DATA_MIN))
			return DATA_MIN;
		else
			return data_t'(v);
	endfunction

	// rounded (ties toward +inf) and saturated Q product
	function automatic data_t qmul(input data_t a, input data_t b);
		acc_t p;
		p = acc_t'(a) * acc_t'(b);
		p = p + acc_t'(QMUL_HALF);
		return sat_data(p >>> FRAC_BITS);
	endfunction

	// lower bound first, then upper, so upper wins on crossed bounds
	function automatic data_t clamp_sat(input acc_t v, input data_t lo, input data_t hi);
		acc_t t;
		t = v;
		if (t < acc_t'(lo))
			t = acc_t'(lo);
		if (t > acc_t'(hi))
			t = acc_t'(hi);
		return sat_data(t);
	endfunction

	// cosine over one full turn from a 28-bit fixed-point Taylor series,
	// evaluated at elaboration only; term n is divided by (2n-1)(2n)
	function automatic cos_tab_t build_cos_table();
		cos_tab_t        tab;
		longint unsigned kk;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned mag;
		longint unsigned r;
		longint          sum;
		longint          v;
		for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
			kk = longint'(k);
			if (kk > longint'(COS_TABLE_DEPTH) - kk)
				kk = longint'(COS_TABLE_DEPTH) - kk;
			x    = (TWO_PI_Q28 * kk) >> COS_IDX_W;
			x2   = (x * x) >> 28;
			term = 64'd1 << 28;
			sum  = longint'(term);
			term = ((term * x2) >> 28) / 64'd2;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 28) / 64'd12;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 28) / 64'd30;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 28) / 64'd56;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 28) / 64'd90;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 28) / 64'd132;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 28) / 64'd182;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 28) / 64'd240;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 28) / 64'd306;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 28) / 64'd380;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 28) / 64'd462;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 28) / 64'd552;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 28) / 64'd650;
			sum  = sum - longint'(term);
			mag = (sum < 0) ? longint'(-sum) : longint'(sum);
			r   = (mag + (64'd1 << (27 - FRAC_BITS))) >> (28 - FRAC_BITS);
			v   = (sum < 0) ? -longint'(r) : longint'(r);
			if (v > longint'(DATA_MAX))
				v = longint'(DATA_MAX);
			if (v < longint'(DATA_MIN))
				v = longint'(DATA_MIN);
			tab[k] = data_t'(v);
		end
		return tab;
	endfunction

	localparam cos_tab_t COS_TABLE = build_cos_table();

endpackage

FILE: sv/ptvc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvc_if
// Valid/ready channels of the corrector: the input word (error update or
// velocity command) and the result word.
// ----------------------------------------------------------------------------
interface ptvc_cmd_if
	import ptvc_pkg::*;
	();
	logic  valid;
	logic  ready;
	logic  kind;
	data_t error_longitudinal;
	data_t error_lateral;
	data_t error_heading;
	data_t linear_in;
	data_t angular_in;

	modport source (
		output valid, kind, error_longitudinal, error_lateral, error_heading,
		       linear_in, angular_in,
		input  ready
	);
	modport sink (
		input  valid, kind, error_longitudinal, error_lateral, error_heading,
		       linear_in, angular_in,
		output ready
	);
endinterface

interface ptvc_rsp_if
	import ptvc_pkg::*;
	();
	logic  valid;
	logic  ready;
	data_t linear_out;
	data_t angular_out;
	data_t filtered_longitudinal;

	modport source (
		output valid, linear_out, angular_out, filtered_longitudinal,
		input  ready
	);
	modport sink (
		input  valid, linear_out, angular_out, filtered_longitudinal,
		output ready
	);
endinterface

FILE: sv/ptvc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvc_cfg_regs
// Gain, filter coefficient and clamp registers behind a plain write port.
// ----------------------------------------------------------------------------
module ptvc_cfg_regs
	import ptvc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t  cfg_q;
	data_t wr_data;

	assign wr_data = data_t'(cfg_data[DATA_WIDTH-1:0]);
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_longitudinal <= '0;
			cfg_q.gain_lateral      <= '0;
			cfg_q.gain_heading      <= '0;
			cfg_q.filter_alpha      <= '1;
			cfg_q.min_linear        <= NEG_ONE_Q;
			cfg_q.max_linear        <= ONE_Q;
			cfg_q.min_angular       <= NEG_ONE_Q;
			cfg_q.max_angular       <= ONE_Q;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_GAIN_LONGITUDINAL: cfg_q.gain_longitudinal <= wr_data;
				CFG_GAIN_LATERAL:      cfg_q.gain_lateral      <= wr_data;
				CFG_GAIN_HEADING:      cfg_q.gain_heading      <= wr_data;
				CFG_FILTER_ALPHA:      cfg_q.filter_alpha      <= cfg_data[ALPHA_BITS-1:0];
				CFG_MIN_LINEAR:        cfg_q.min_linear        <= wr_data;
				CFG_MAX_LINEAR:        cfg_q.max_linear        <= wr_data;
				CFG_MIN_ANGULAR:       cfg_q.min_angular       <= wr_data;
				CFG_MAX_ANGULAR:       cfg_q.max_angular       <= wr_data;
			endcase
		end
	end

endmodule

FILE: sv/ptvc_cos_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvc_cos_lookup
// Cosine of the lateral error: table index by reciprocal multiply, then a
// constant-table read.
// ----------------------------------------------------------------------------
module ptvc_cos_lookup
	import ptvc_pkg::*;
(
	input  data_t lateral,
	output data_t cos_value
);

	logic [DATA_WIDTH-1:0]              mag;
	logic [COS_NUM_W-1:0]               num;
	logic [COS_NUM_W+COS_RECIP_W-1:0]   prod;
	logic [COS_IDX_W-1:0]               idx;

	always_comb begin
		// magnitude fits unsigned, including the most negative code
		mag  = lateral[DATA_WIDTH-1] ? (~lateral + 1'b1) : lateral;
		num  = (COS_NUM_W'(mag) << COS_IDX_W) + COS_NUM_W'(COS_TWO_PI >> 1);
		prod = {{COS_RECIP_W{1'b0}}, num} *
		       {{COS_NUM_W{1'b0}}, COS_RECIP_W'(COS_RECIP)};
		// quotient modulo depth: low index bits above the reciprocal point
		idx       = prod[COS_RECIP_SHIFT +: COS_IDX_W];
		cos_value = COS_TABLE[idx];
	end

endmodule

FILE: sv/ptvc_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvc_update
// Tracking state: one-pole low-pass on the longitudinal error, stored
// lateral and heading errors, and the cosine of the lateral error.
// ----------------------------------------------------------------------------
module ptvc_update
	import ptvc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  data_t  error_longitudinal,
	input  data_t  error_lateral,
	input  data_t  error_heading,
	input  alpha_t filter_alpha,
	output data_t  filtered_next,
	output track_t track
);

	track_t track_q;
	data_t  cos_new;
	acc_t   diff;
	acc_t   step_prod;

	ptvc_cos_lookup u_cos (
		.lateral   (error_lateral),
		.cos_value (cos_new)
	);

	// filt += round(alpha * (e - filt) / 2^16)
	always_comb begin
		diff          = acc_t'(error_longitudinal) - acc_t'(track_q.filtered_long_error);
		step_prod     = diff * acc_t'({1'b0, filter_alpha});
		step_prod     = step_prod + acc_t'(ALPHA_HALF);
		filtered_next = sat_data(acc_t'(track_q.filtered_long_error) +
		                         (step_prod >>> ALPHA_BITS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q.filtered_long_error <= '0;
			track_q.lateral_error       <= '0;
			track_q.heading_error       <= '0;
			track_q.cos_lateral         <= ONE_Q;
		end else if (load) begin
			track_q.filtered_long_error <= filtered_next;
			track_q.lateral_error       <= error_lateral;
			track_q.heading_error       <= error_heading;
			track_q.cos_lateral         <= cos_new;
		end
	end

	assign track = track_q;

endmodule

FILE: sv/ptvc_correct.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvc_correct
// Velocity command correction from the stored tracking errors, with
// saturating products and clamped outputs.
// ----------------------------------------------------------------------------
module ptvc_correct
	import ptvc_pkg::*;
(
	input  data_t  linear_in,
	input  data_t  angular_in,
	input  track_t track,
	input  cfg_t   cfg,
	output data_t  linear,
	output data_t  angular
);

	acc_t ang_sum;
	acc_t lin_sum;

	always_comb begin
		ang_sum = acc_t'(angular_in)
		        + acc_t'(qmul(cfg.gain_lateral, track.lateral_error))
		        - acc_t'(qmul(cfg.gain_heading, track.heading_error));
		lin_sum = acc_t'(qmul(linear_in, track.cos_lateral))
		        - acc_t'(qmul(cfg.gain_longitudinal, track.filtered_long_error));
		angular = clamp_sat(ang_sum, cfg.min_angular, cfg.max_angular);
		linear  = clamp_sat(lin_sum, cfg.min_linear, cfg.max_linear);
	end

endmodule

FILE: sv/path_tracking_velocity_corrector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_tracking_velocity_corrector_core
// Path-tracking velocity corrector with one-pole low-pass on the
// longitudinal error, Q4.12 fixed point.
//
// Usage:
//   cmd  : input words, valid/ready. kind 0 is a tracking-error update,
//          kind 1 a velocity command to correct.
//   rsp  : one result word per input word, valid/ready, in order.
//   cfg_we/cfg_index/cfg_data : register writes, taken on any cycle with
//          cfg_we high; write only while no word is in flight.
//   An accepted word is held in the input register, then moves to the result
//   register, which drives rsp.valid. One word is accepted per cycle while
//   rsp.ready is high; the filter recurrence and the correction each fit
//   in the single compute stage between the input and result registers.
//   When rsp stalls, the result register holds its word and the input
//   register can still take one more word, after which cmd.ready drops.
//   Reset clears both stages, zeroes the tracking errors and filter state,
//   sets the stored cosine to 1.0 and loads the register reset values.
// ----------------------------------------------------------------------------
module path_tracking_velocity_corrector_core
	import ptvc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	ptvc_cmd_if.sink              cmd,
	ptvc_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg;
	track_t track;

	logic   valid_s1;
	logic   kind_s1;
	data_t  err_long_s1;
	data_t  err_lat_s1;
	data_t  err_head_s1;
	data_t  linear_in_s1;
	data_t  angular_in_s1;

	logic   valid_s2;
	data_t  linear_s2;
	data_t  angular_s2;
	data_t  filtered_s2;

	logic   advance;
	logic   step;
	logic   upd_step;
	data_t  filtered_next;
	data_t  linear_c;
	data_t  angular_c;

	assign advance   = !valid_s2 || rsp.ready;
	assign step      = valid_s1 && advance;
	assign upd_step  = step && (kind_s1 == KIND_UPDATE);
	assign cmd.ready = !valid_s1 || advance;

	ptvc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ptvc_update u_update (
		.clk                (clk),
		.arst_n             (arst_n),
		.load               (upd_step),
		.error_longitudinal (err_long_s1),
		.error_lateral      (err_lat_s1),
		.error_heading      (err_head_s1),
		.filter_alpha       (cfg.filter_alpha),
		.filtered_next      (filtered_next),
		.track              (track)
	);

	ptvc_correct u_correct (
		.linear_in  (linear_in_s1),
		.angular_in (angular_in_s1),
		.track      (track),
		.cfg        (cfg),
		.linear     (linear_c),
		.angular    (angular_c)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_s1       <= cmd.kind;
			err_long_s1   <= cmd.error_longitudinal;
			err_lat_s1    <= cmd.error_lateral;
			err_head_s1   <= cmd.error_heading;
			linear_in_s1  <= cmd.linear_in;
			angular_in_s1 <= cmd.angular_in;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (kind_s1 == KIND_COMMAND) begin
				linear_s2   <= linear_c;
				angular_s2  <= angular_c;
				filtered_s2 <= track.filtered_long_error;
			end else begin
				linear_s2   <= '0;
				angular_s2  <= '0;
				filtered_s2 <= filtered_next;
			end
		end
	end

	assign rsp.valid                 = valid_s2;
	assign rsp.linear_out            = linear_s2;
	assign rsp.angular_out           = angular_s2;
	assign rsp.filtered_longitudinal = filtered_s2;

	// an empty result register never back-pressures the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> cmd.ready)
		else $error("cmd.ready low with empty result register");

	// an update's result reports the filter state it leaves behind
	a_update_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		upd_step |=> (filtered_s2 == track.filtered_long_error))
		else $error("update result differs from stored filter state");

	// tracking state only moves on an update word
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!upd_step |=> $stable(track))
		else $error("tracking state changed without an update word");

	// a new result only ever comes from a word held in the input register
	a_result_from_stage1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result appeared without a word in the input register");

endmodule

FILE: tb/tb_path_tracking_velocity_corrector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_path_tracking_velocity_corrector_core
// Self-checking bench for the path-tracking velocity corrector. A scoreboard
// class keeps its own copy of the filter state, tracking errors, cosine
// table and registers, predicts each result word, and compares it field by
// field. Directed corner words come first, then random phases under changing
// register settings; random idle and stall bursts in all but the last phase.
// ----------------------------------------------------------------------------
module tb_path_tracking_velocity_corrector_core;
	import ptvc_pkg::*;

	typedef struct packed {
		kind_t kind;
		data_t err_long;
		data_t err_lat;
		data_t err_head;
		data_t lin_cmd;
		data_t ang_cmd;
	} cmd_word_t;

	typedef struct packed {
		data_t lin;
		data_t ang;
		data_t filt;
	} rsp_word_t;

	localparam longint unsigned TURN_Q28 = 64'd1686629713;
	localparam longint unsigned TURN_Q32 = 64'd26986075409;
	// 2*pi in data format, rounded
	localparam longint unsigned TURN_Q =
		(TURN_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	localparam int SPAN        = 2 * (1 << FRAC_BITS);
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 200;

	class corrector_scoreboard;
		data_t  gain_long;
		data_t  gain_lat;
		data_t  gain_head;
		alpha_t alpha;
		data_t  lin_lo;
		data_t  lin_hi;
		data_t  ang_lo;
		data_t  ang_hi;
		data_t  filt_long;
		data_t  lat_err;
		data_t  head_err;
		data_t  cos_lat;
		data_t  cos_lut [COS_TABLE_DEPTH];
		rsp_word_t expected_speeds [$];
		int faults;

		function new();
			for (int k = 0; k < COS_TABLE_DEPTH; k++)
				cos_lut[k] = cos_point(k);
			gain_long = '0;
			gain_lat  = '0;
			gain_head = '0;
			alpha     = '1;
			lin_lo    = NEG_ONE_Q;
			lin_hi    = ONE_Q;
			ang_lo    = NEG_ONE_Q;
			ang_hi    = ONE_Q;
			filt_long = '0;
			lat_err   = '0;
			head_err  = '0;
			cos_lat   = ONE_Q;
			faults    = 0;
		endfunction

		function data_t sat16(longint v);
			if (v > longint'(DATA_MAX))
				return DATA_MAX;
			if (v < longint'(DATA_MIN))
				return DATA_MIN;
			return data_t'(v);
		endfunction

		// round to nearest, ties toward +inf
		function longint round_shift(longint v, int s);
			return (v + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function longint qprod(data_t a, data_t b);
			return longint'(sat16(round_shift(longint'(a) * longint'(b), FRAC_BITS)));
		endfunction

		function data_t bound(longint v, data_t lo, data_t hi);
			if (v < longint'(lo))
				v = longint'(lo);
			if (v > longint'(hi))
				v = longint'(hi);
			return sat16(v);
		endfunction

		// Taylor series in 28-bit fraction, folded around the half turn
		function data_t cos_point(int k);
			longint unsigned kk;
			longint unsigned x;
			longint unsigned x2;
			longint unsigned term;
			longint unsigned mag;
			longint unsigned r;
			longint acc;
			kk = (k > COS_TABLE_DEPTH - k) ? COS_TABLE_DEPTH - k : k;
			x = (TURN_Q28 * kk) / COS_TABLE_DEPTH;
			x2 = (x * x) >> 28;
			term = 64'd1 << 28;
			acc = longint'(term);
			for (int n = 1; n <= 13; n++) begin
				term = ((term * x2) >> 28) / longint'((2 * n - 1) * (2 * n));
				if (n % 2 == 1)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			mag = (acc < 0) ? longint'(-acc) : longint'(acc);
			r = (mag + (64'd1 << (27 - FRAC_BITS))) >> (28 - FRAC_BITS);
			return sat16((acc < 0) ? -longint'(r) : longint'(r));
		endfunction

		function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_GAIN_LONGITUDINAL: gain_long = data_t'(value);
				CFG_GAIN_LATERAL:      gain_lat  = data_t'(value);
				CFG_GAIN_HEADING:      gain_head = data_t'(value);
				CFG_FILTER_ALPHA:      alpha     = alpha_t'(value);
				CFG_MIN_LINEAR:        lin_lo    = data_t'(value);
				CFG_MAX_LINEAR:        lin_hi    = data_t'(value);
				CFG_MIN_ANGULAR:       ang_lo    = data_t'(value);
				CFG_MAX_ANGULAR:       ang_hi    = data_t'(value);
			endcase
		endfunction

		function void note_word(cmd_word_t w);
			rsp_word_t r;
			longint diff;
			longint unsigned mag;
			longint unsigned idx;
			longint lin;
			longint ang;
			r = '0;
			if (w.kind == KIND_UPDATE) begin
				diff = longint'(w.err_long) - longint'(filt_long);
				filt_long = sat16(longint'(filt_long)
					+ round_shift(longint'(alpha) * diff, ALPHA_BITS));
				lat_err  = w.err_lat;
				head_err = w.err_head;
				mag = (lat_err < 0) ? longint'(-longint'(lat_err)) : longint'(lat_err);
				idx = (mag * COS_TABLE_DEPTH + TURN_Q / 2) / TURN_Q;
				cos_lat = cos_lut[idx % COS_TABLE_DEPTH];
			end else begin
				ang = longint'(w.ang_cmd) + qprod(gain_lat, lat_err)
					- qprod(gain_head, head_err);
				lin = qprod(w.lin_cmd, cos_lat) - qprod(gain_long, filt_long);
				r.ang = bound(ang, ang_lo, ang_hi);
				r.lin = bound(lin, lin_lo, lin_hi);
			end
			r.filt = filt_long;
			expected_speeds.push_back(r);
		endfunction

		function void compare_field(string name, data_t want, data_t got);
			if (got !== want) begin
				faults++;
				if (faults <= 10)
					$display("%0t: %s mismatch: expected %0d, got %0d", $time, name,
						want, got);
			end
		endfunction

		function void check_word(rsp_word_t got);
			rsp_word_t want;
			if (expected_speeds.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: unexpected result word lin %0d ang %0d filt %0d",
						$time, got.lin, got.ang, got.filt);
				return;
			end
			want = expected_speeds.pop_front();
			compare_field("linear_out", want.lin, got.lin);
			compare_field("angular_out", want.ang, got.ang);
			compare_field("filtered_longitudinal", want.filt, got.filt);
		endfunction

		function int pending();
			return expected_speeds.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit calm;
	corrector_scoreboard sb;

	ptvc_cmd_if cmd_ch ();
	ptvc_rsp_if rsp_ch ();

	path_tracking_velocity_corrector_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic data_t pick_data();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 5))
					0: return DATA_MIN;
					1: return DATA_MAX;
					2: return '0;
					3: return ONE_Q;
					4: return NEG_ONE_Q;
					default: return '1;
				endcase
			end
			1, 2, 3: return data_t'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic alpha_t pick_alpha();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return alpha_t'(1);
			2: return '1;
			3: return alpha_t'(16'h8000);
			default: return alpha_t'($urandom);
		endcase
	endfunction

	// mostly ordered bounds, sometimes crossed
	task automatic pick_bounds(output data_t lo, output data_t hi);
		data_t a;
		data_t b;
		a = pick_data();
		b = pick_data();
		if (a > b && $urandom_range(0, 4) != 0) begin
			lo = b;
			hi = a;
		end else begin
			lo = a;
			hi = b;
		end
	endtask

	function automatic cmd_word_t random_word();
		cmd_word_t w;
		w.kind     = kind_t'($urandom_range(0, 1));
		w.err_long = pick_data();
		w.err_lat  = pick_data();
		w.err_head = pick_data();
		w.lin_cmd  = pick_data();
		w.ang_cmd  = pick_data();
		return w;
	endfunction

	task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	task automatic write_regs(input data_t g_long, input data_t g_lat, input data_t g_head,
		input alpha_t a, input data_t l_lo, input data_t l_hi,
		input data_t a_lo, input data_t a_hi);
		put_reg(CFG_GAIN_LONGITUDINAL, g_long);
		put_reg(CFG_GAIN_LATERAL, g_lat);
		put_reg(CFG_GAIN_HEADING, g_head);
		put_reg(CFG_FILTER_ALPHA, a);
		put_reg(CFG_MIN_LINEAR, l_lo);
		put_reg(CFG_MAX_LINEAR, l_hi);
		put_reg(CFG_MIN_ANGULAR, a_lo);
		put_reg(CFG_MAX_ANGULAR, a_hi);
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(input cmd_word_t w);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid              <= 1'b1;
		cmd_ch.kind               <= w.kind;
		cmd_ch.error_longitudinal <= w.err_long;
		cmd_ch.error_lateral      <= w.err_lat;
		cmd_ch.error_heading      <= w.err_head;
		cmd_ch.linear_in          <= w.lin_cmd;
		cmd_ch.angular_in         <= w.ang_cmd;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		sb.note_word(w);
	endtask

	task automatic send_fields(input kind_t k, input data_t e_long, input data_t e_lat,
		input data_t e_head, input data_t lin, input data_t ang);
		cmd_word_t w;
		w.kind     = k;
		w.err_long = e_long;
		w.err_lat  = e_lat;
		w.err_head = e_head;
		w.lin_cmd  = lin;
		w.ang_cmd  = ang;
		send_word(w);
	endtask

	// drain before register writes: every word yields one result
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// result side: check accepted words, stall in random bursts
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				sb.check_word({rsp_ch.linear_out, rsp_ch.angular_out,
					rsp_ch.filtered_longitudinal});
			if (!calm && stall == 0 && $urandom_range(0, 7) == 0)
				stall = $urandom_range(1, 13);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		data_t l_lo;
		data_t l_hi;
		data_t a_lo;
		data_t a_hi;
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_GAIN_LONGITUDINAL;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = KIND_UPDATE;
		cmd_ch.error_longitudinal = '0;
		cmd_ch.error_lateral = '0;
		cmd_ch.error_heading = '0;
		cmd_ch.linear_in = '0;
		cmd_ch.angular_in = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: unity cosine, clamps at +/-1.0
		send_fields(KIND_COMMAND, '0, '0, '0, DATA_MAX, DATA_MIN);
		send_fields(KIND_COMMAND, '0, '0, '0, DATA_MIN, DATA_MAX);
		send_fields(KIND_UPDATE, DATA_MAX, DATA_MIN, DATA_MAX, '0, '0);
		send_fields(KIND_COMMAND, '0, '0, '0, ONE_Q, '0);
		send_fields(KIND_UPDATE, DATA_MIN, DATA_MAX, DATA_MIN, '1, '1);
		// half turn, cosine -1
		send_fields(KIND_UPDATE, '0, data_t'(12868), '0, '0, '0);
		send_fields(KIND_COMMAND, '0, '0, '0, ONE_Q, NEG_ONE_Q);
		settle();

		// saturating gains, filter frozen, crossed linear bounds
		write_regs(DATA_MAX, DATA_MIN, DATA_MAX, '0, DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX);
		// full turn wraps to table entry zero
		send_fields(KIND_UPDATE, DATA_MAX, data_t'(25736), DATA_MIN, '0, '0);
		send_fields(KIND_COMMAND, '0, '0, '0, DATA_MAX, DATA_MAX);
		send_fields(KIND_COMMAND, '0, '0, '0, DATA_MIN, DATA_MIN);
		send_fields(KIND_UPDATE, DATA_MIN, data_t'(-12868), DATA_MAX, '0, '0);
		send_fields(KIND_COMMAND, '0, '0, '0, '0, '0);
		settle();

		// smallest nonzero alpha exercises filter rounding
		write_regs(ONE_Q, NEG_ONE_Q, ONE_Q, alpha_t'(1), data_t'(-SPAN), data_t'(SPAN),
			data_t'(-SPAN), data_t'(SPAN));
		send_fields(KIND_UPDATE, DATA_MAX, '1, data_t'(1), '0, '0);
		send_fields(KIND_UPDATE, DATA_MIN, '1, data_t'(1), '0, '0);
		send_fields(KIND_COMMAND, '0, '0, '0, ONE_Q, '0);
		send_fields(KIND_UPDATE, data_t'(100), data_t'(6434), NEG_ONE_Q, '0, '0);
		send_fields(KIND_COMMAND, '0, '0, '0, NEG_ONE_Q, ONE_Q);
		send_fields(KIND_UPDATE, '0, '0, '0, '0, '0);
		send_fields(KIND_COMMAND, '0, '0, '0, DATA_MAX, DATA_MIN);

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: write_regs(DATA_MAX, DATA_MAX, DATA_MAX, '1, DATA_MIN, DATA_MAX,
					DATA_MIN, DATA_MAX);
				1: write_regs(DATA_MIN, DATA_MIN, DATA_MIN, '0, ONE_Q, NEG_ONE_Q,
					ONE_Q, NEG_ONE_Q);
				default: begin
					pick_bounds(l_lo, l_hi);
					pick_bounds(a_lo, a_hi);
					write_regs(pick_data(), pick_data(), pick_data(), pick_alpha(),
						l_lo, l_hi, a_lo, a_hi);
				end
			endcase
			// last phase runs back to back on both sides
			calm = (phase == PHASES - 1);
			repeat (PHASE_WORDS) send_word(random_word());
		end
		settle();

		if (sb.faults == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
